### sv/escaped_length_frame_deframer_top_defines.svh
// Assertion macros shared by the escaped length frame deframer.
`ifndef ESCAPED_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define ESCAPED_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ELD_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("eld check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ELD_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("eld check failed: next-cycle implication");

`endif

### sv/eld_pkg.sv
// Package with the framing constants and shared types of the deframer.
package eld_pkg;

    // Framing byte codes.
    localparam logic [7:0] HDR_BYTE = 8'hE0;
    localparam logic [7:0] ESC_BYTE = 8'hD0;
    localparam logic [7:0] ESC_HDR  = 8'hDF;

    // One decoded result as it travels through the queue.
    typedef struct packed {
        logic [7:0] payload;
        logic       first;
        logic       last;
    } result_t;

    // Parser state visible to the top level.
    typedef struct packed {
        logic in_frame;
        logic escape_pending;
    } front_status_t;

endpackage

### sv/eld_front.sv
// Front end: accepts raw bytes, tracks framing state and decodes escapes.
module eld_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   queue_full,
    output logic                   push,
    output eld_pkg::result_t       push_data,
    output eld_pkg::front_status_t status
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic       escape_reg;
    logic       escape_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;

    logic       accept;
    logic       is_hdr;
    logic       is_esc;
    logic       count_at_end;
    logic [7:0] count_inc;
    logic [7:0] decoded;

    // Input side is ready whenever the queue has room.
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign is_hdr    = (in_byte == eld_pkg::HDR_BYTE);
    assign is_esc    = (in_byte == eld_pkg::ESC_BYTE);
    assign count_inc = count_reg + 8'd1;
    assign count_at_end = (count_inc >= length_reg);

    // Escaped bytes decode to a header code or to the escape code itself.
    always_comb
    begin
        if (escape_reg)
        begin
            decoded = (in_byte == eld_pkg::ESC_HDR) ? eld_pkg::HDR_BYTE : eld_pkg::ESC_BYTE;
        end
        else
        begin
            decoded = in_byte;
        end
    end

    // Classify the byte and work out the next framing state.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        escape_next   = escape_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        push          = 1'b0;
        if (accept)
        begin
            if (is_hdr)
            begin
                in_frame_next = 1'b1;
                escape_next   = 1'b0;
                length_next   = 8'd0;
                count_next    = 8'd0;
            end
            else if (in_frame_reg)
            begin
                if (length_reg == 8'd0)
                begin
                    length_next = in_byte;
                end
                else if (!escape_reg && is_esc)
                begin
                    escape_next = 1'b1;
                end
                else
                begin
                    escape_next = 1'b0;
                    count_next  = count_inc;
                    push        = 1'b1;
                    if (count_at_end)
                    begin
                        in_frame_next = 1'b0;
                    end
                end
            end
        end
    end

    assign push_data.payload = decoded;
    assign push_data.first   = (count_reg == 8'd0);
    assign push_data.last    = count_at_end;

    assign status.in_frame       = in_frame_reg;
    assign status.escape_pending = escape_reg;

    // Framing state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            escape_reg   <= 1'b0;
            length_reg   <= 8'd0;
            count_reg    <= 8'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            escape_reg   <= escape_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
        end
    end

endmodule

### sv/eld_queue.sv
// Short result queue between the front end and the output channel.
module eld_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  eld_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output eld_pkg::result_t out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    eld_pkg::result_t entries_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign full      = (count_reg == FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer wrap and occupancy tracking.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/escaped_length_frame_deframer_top.sv
// Top level of the escaped length frame deframer.
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid/in_ready    in_byte[7:0]
//  output    out        out_valid/out_ready  payload_byte[7:0], frame_first, frame_last
//
// One byte is taken every cycle while the result queue has room; the front end
// parses and decodes it in that same cycle. A decoded byte is registered in the
// queue and reaches the output after any older entries. The QUEUE_DEPTH entries
// of the queue set how long the output may stall before in_ready drops. Reset
// clears the framing state and empties the queue; no clearing pass is needed.
`include "escaped_length_frame_deframer_top_defines.svh"

module escaped_length_frame_deframer_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       frame_first,
    output logic       frame_last
);

    logic                   queue_full;
    logic                   push;
    eld_pkg::result_t       push_data;
    eld_pkg::result_t       out_data;
    eld_pkg::front_status_t status;
    logic                   hdr_accept;

    // Parser and escape decoder.
    eld_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data),
        .status     (status)
    );

    // Result queue feeding the output channel.
    eld_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign payload_byte = out_data.payload;
    assign frame_first  = out_data.first;
    assign frame_last   = out_data.last;

    // A header byte taken in this cycle.
    assign hdr_accept = in_valid && in_ready && (in_byte == eld_pkg::HDR_BYTE);

    // A header byte never produces a result.
    `ELD_ASSERT_NOW(a_hdr_no_push, hdr_accept, !push)
    // A header opens a frame with no escape outstanding.
    `ELD_ASSERT_NEXT(a_hdr_opens, hdr_accept, status.in_frame && !status.escape_pending)
    // The last byte of a frame closes it.
    `ELD_ASSERT_NEXT(a_last_closes, push && push_data.last, !status.in_frame)

endmodule

### dv/deframe_scoreboard.sv
// Scoreboard that predicts and checks the decoded output of the escaped length frame deframer.
`timescale 1ns / 1ps

module deframe_scoreboard
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] payload_byte,
    input  logic       frame_first,
    input  logic       frame_last,
    output int         mismatch_count,
    output int         bytes_outstanding
);

    // Our own copy of the framing state.
    logic       frame_open;
    logic       escape_seen;
    logic [7:0] frame_length;
    logic [7:0] byte_count;

    // Decoded bytes still owed by the block, oldest first.
    eld_pkg::result_t decoded_fifo [$];
    int               mismatches;

    // Advances the framing state by one raw byte; returns 1 when a byte is decoded.
    function automatic bit deframe_byte(input logic [7:0] raw, output eld_pkg::result_t res);
        logic [7:0] data;
        res = '0;
        // A header always opens a fresh frame, even straight after an escape.
        if (raw == eld_pkg::HDR_BYTE)
        begin
            frame_open   = 1'b1;
            escape_seen  = 1'b0;
            frame_length = 8'd0;
            byte_count   = 8'd0;
            return 1'b0;
        end
        if (!frame_open)
            return 1'b0;
        // A zero length keeps us waiting for the length.
        if (frame_length == 8'd0)
        begin
            frame_length = raw;
            return 1'b0;
        end
        if (escape_seen)
        begin
            data        = (raw == eld_pkg::ESC_HDR) ? eld_pkg::HDR_BYTE : eld_pkg::ESC_BYTE;
            escape_seen = 1'b0;
        end
        else if (raw == eld_pkg::ESC_BYTE)
        begin
            escape_seen = 1'b1;
            return 1'b0;
        end
        else
        begin
            data = raw;
        end
        res.payload = data;
        res.first   = (byte_count == 8'd0);
        byte_count  = byte_count + 8'd1;
        res.last    = (byte_count >= frame_length);
        if (res.last)
            frame_open = 1'b0;
        return 1'b1;
    endfunction

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: deframer mismatch: %s", $time, what);
    endtask

    // Outputs are compared before inputs are predicted: a byte taken at this edge
    // cannot have its result at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        eld_pkg::result_t want;
        eld_pkg::result_t got;
        if (!rst_n)
        begin
            frame_open   = 1'b0;
            escape_seen  = 1'b0;
            frame_length = 8'd0;
            byte_count   = 8'd0;
            decoded_fifo.delete();
            mismatches   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_fifo.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transaction: byte %02h first %0b last %0b",
                                              payload_byte, frame_first, frame_last));
                end
                else
                begin
                    want = decoded_fifo.pop_front();
                    if (payload_byte !== want.payload)
                        report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                                  payload_byte, want.payload));
                    if (frame_first !== want.first)
                        report_mismatch($sformatf("frame_first %0b, expected %0b on byte %02h",
                                                  frame_first, want.first, want.payload));
                    if (frame_last !== want.last)
                        report_mismatch($sformatf("frame_last %0b, expected %0b on byte %02h",
                                                  frame_last, want.last, want.payload));
                end
            end
            if (in_valid && in_ready)
            begin
                if (deframe_byte(in_byte, got))
                    decoded_fifo.insert(decoded_fifo.size(), got);
            end
        end
        // Published with nonblocking updates so the stimulus side reads them race free.
        mismatch_count    <= mismatches;
        bytes_outstanding <= decoded_fifo.size();
    end

endmodule

### dv/escaped_length_frame_deframer_top_test.sv
// Testbench top that drives framed byte streams into the deframer and gives the verdict.
`timescale 1ns / 1ps

module escaped_length_frame_deframer_top_test;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] payload_byte;
    logic       frame_first;
    logic       frame_last;
    int         mismatch_count;
    int         bytes_outstanding;

    int         bytes_sent;
    bit         sender_steady;

    // Opening sequence: dropped bytes, escapes, zero length, restarts and the byte extremes.
    localparam logic [7:0] OPENING [0:24] = '{
        8'h55, eld_pkg::ESC_BYTE,
        eld_pkg::HDR_BYTE, 8'h03, 8'h00, 8'hFF, eld_pkg::ESC_BYTE, eld_pkg::ESC_HDR,
        eld_pkg::HDR_BYTE, 8'h00, 8'h02, eld_pkg::ESC_BYTE, 8'h12, eld_pkg::ESC_BYTE,
        eld_pkg::HDR_BYTE, 8'h01, eld_pkg::ESC_BYTE, eld_pkg::ESC_BYTE,
        eld_pkg::HDR_BYTE, 8'h04, 8'hAA, eld_pkg::HDR_BYTE, 8'h01, 8'h7F,
        8'h33
    };

    escaped_length_frame_deframer_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_byte (payload_byte),
        .frame_first  (frame_first),
        .frame_last   (frame_last)
    );

    deframe_scoreboard u_scoreboard (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_byte           (in_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .payload_byte      (payload_byte),
        .frame_first       (frame_first),
        .frame_last        (frame_last),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, none while the sender runs steady.
    function automatic int unsigned sender_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (sender_steady || roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One input transaction: optional idle gap, then hold valid until accepted.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = sender_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // A framed payload with escapes; now and then cut short or left on a dangling escape.
    task automatic send_frame(input int unsigned length);
        int unsigned stop_at;
        int unsigned kind;
        logic [7:0]  data;
        logic [7:0]  follow;
        stop_at = length;
        if ($urandom_range(0, 9) == 0)
            stop_at = $urandom_range(0, length - 1);
        send_byte(eld_pkg::HDR_BYTE);
        // A zero length byte leaves the frame still waiting for its length.
        if ($urandom_range(0, 9) == 0)
        begin
            for (int z = 0; z < $urandom_range(1, 2); z++)
                send_byte(8'h00);
        end
        send_byte(length[7:0]);
        for (int i = 0; i < stop_at; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                send_byte(eld_pkg::ESC_BYTE);
                send_byte(eld_pkg::ESC_HDR);
            end
            else if (kind == 1)
            begin
                // Any escaped byte other than the header code decodes to the escape code.
                do
                    follow = 8'($urandom_range(0, 255));
                while (follow == eld_pkg::HDR_BYTE || follow == eld_pkg::ESC_HDR);
                send_byte(eld_pkg::ESC_BYTE);
                send_byte(follow);
            end
            else
            begin
                do
                    data = 8'($urandom_range(0, 255));
                while (data == eld_pkg::HDR_BYTE || data == eld_pkg::ESC_BYTE);
                send_byte(data);
            end
        end
        if (stop_at < length && $urandom_range(0, 1) == 1)
            send_byte(eld_pkg::ESC_BYTE);
    endtask

    // Picks a frame length, mostly short, sometimes long.
    function automatic int unsigned frame_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 8);
        if (roll < 97)
            return $urandom_range(9, 40);
        return $urandom_range(150, 255);
    endfunction

    // Receiver: runs of ready broken by stalls, with occasional long runs.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(100, 300)) @(posedge clk);
            else
                repeat ($urandom_range(1, 20)) @(posedge clk);
            out_ready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 50)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        bytes_sent    = 0;
        sender_steady = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING[k])
            send_byte(OPENING[k]);

        // The longest frame the length byte allows.
        sender_steady = 1'b1;
        send_frame(255);

        while (bytes_sent < 900)
        begin
            sender_steady = ($urandom_range(0, 7) == 0);
            // Stray bytes between frames, a header among them now and then.
            if ($urandom_range(0, 3) == 0)
            begin
                for (int n = 0; n < $urandom_range(1, 3); n++)
                    send_byte(8'($urandom_range(0, 255)));
            end
            send_frame(frame_size());
        end
        in_valid <= 1'b0;

        // Drain, then leave room for any stray output.
        @(posedge clk);
        while (bytes_outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("escaped_length_frame_deframer_top regression: pass");
        else
            $display("escaped_length_frame_deframer_top regression: fail");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("escaped_length_frame_deframer_top regression: fail");
        $finish;
    end

endmodule
